@@ rtl/tfck_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tfck_pkg;

    // default tile edge and the widest tile the command format can address
    localparam int TILE_SIZE_DEF   = 16;
    localparam int TILE_SIZE_MAX   = 32;
    localparam int MAX_AW          = $clog2(TILE_SIZE_MAX * TILE_SIZE_MAX);
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] FRAME_WIDTH_RST = 16'd320;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_RENDER = 2'd1,
        KIND_FLIP   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ROW
    } back_state_t;

    // one command handed from front to back
    typedef struct packed {
        logic              is_render;
        logic [MAX_AW-1:0] addr;       // load: store address, render: row base address
        logic [7:0]        value;
        logic              hflip;
        logic [15:0]       ry;
        logic [15:0]       dx;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/tfck_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tfck_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire tfck_pkg::cmd_t push_data,
    output logic                push_ready,
    input  wire logic           pop,
    output logic                pop_valid,
    output tfck_pkg::cmd_t      pop_data
);
    import tfck_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tfck_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tfck_front #(
    parameter int TILE_SIZE = tfck_pkg::TILE_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  pixel_index,
    input  wire logic [7:0]  pixel_value,
    input  wire logic [3:0]  tile_row,
    input  wire logic [15:0] dest_x,
    input  wire logic [15:0] dest_y,
    input  wire logic [1:0]  flip_mode,
    output logic             push,
    output tfck_pkg::cmd_t   push_data,
    input  wire logic        push_ready
);
    import tfck_pkg::*;

    localparam int CW    = $clog2(TILE_SIZE);
    localparam int AW    = $clog2(TILE_SIZE * TILE_SIZE);
    localparam int RECIP = 65536 / TILE_SIZE + 1;

    // the stored tile is never moved: a flip only toggles how logical
    // coordinates map onto the store
    logic          mh_reg, mh_next;
    logic          mv_reg, mv_next;
    logic          accept;
    logic          pix_ok, row_ok;
    logic [24:0]   quot_prod;
    logic [CW-1:0] ld_row, ld_col, ld_prow, ld_pcol;
    logic [7:0]    ld_rem;
    logic [AW-1:0] ld_addr;
    logic [CW-1:0] rd_row, rd_prow;
    logic [AW-1:0] rd_base;
    logic          eff_v;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign pix_ok   = (int'(pixel_index) < TILE_SIZE * TILE_SIZE);
    assign row_ok   = (int'(tile_row) < TILE_SIZE);

    // row = index / TILE_SIZE by reciprocal multiply, exact for 8-bit indexes
    assign quot_prod = 25'(pixel_index) * 25'(RECIP);
    assign ld_row    = quot_prod[16 +: CW];
    assign ld_rem    = pixel_index - 8'(int'(ld_row) * TILE_SIZE);
    assign ld_col    = ld_rem[CW-1:0];
    assign ld_prow   = mv_reg ? CW'(TILE_SIZE - 1) - ld_row : ld_row;
    assign ld_pcol   = mh_reg ? CW'(TILE_SIZE - 1) - ld_col : ld_col;
    assign ld_addr   = AW'(int'(ld_prow) * TILE_SIZE) + AW'(ld_pcol);

    assign eff_v   = flip_mode[1] ^ mv_reg;
    assign rd_row  = CW'(tile_row);
    assign rd_prow = eff_v ? CW'(TILE_SIZE - 1) - rd_row : rd_row;
    assign rd_base = AW'(int'(rd_prow) * TILE_SIZE);

    always_comb begin
        mh_next             = mh_reg;
        mv_next             = mv_reg;
        push                = 1'b0;
        push_data.is_render = 1'b0;
        push_data.addr      = MAX_AW'(ld_addr);
        push_data.value     = pixel_value;
        push_data.hflip     = flip_mode[0] ^ mh_reg;
        push_data.ry        = dest_y + 16'(tile_row);
        push_data.dx        = dest_x;
        unique case (kind)
            KIND_LOAD: begin
                push = in_valid && pix_ok;
            end
            KIND_RENDER: begin
                push                = in_valid && row_ok;
                push_data.is_render = 1'b1;
                push_data.addr      = MAX_AW'(rd_base);
            end
            KIND_FLIP: begin
                if (accept) begin
                    mh_next = mh_reg ^ flip_mode[0];
                    mv_next = mv_reg ^ flip_mode[1];
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mh_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            mh_reg <= mh_next;
            mv_reg <= mv_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tfck_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tfck_back #(
    parameter int TILE_SIZE = tfck_pkg::TILE_SIZE_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_wdata,
    input  wire logic           q_valid,
    input  wire tfck_pkg::cmd_t q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [31:0]         out_addr,
    output logic [7:0]          out_pixel,
    output logic                out_last
);
    import tfck_pkg::*;

    localparam int CW  = $clog2(TILE_SIZE);
    localparam int CNT = $clog2(TILE_SIZE + 1);
    localparam int AW  = $clog2(TILE_SIZE * TILE_SIZE);
    localparam int NPX = TILE_SIZE * TILE_SIZE;

    back_state_t   state_reg, state_next;
    cmd_t          cmd_reg;
    logic [15:0]   frame_width_reg;
    logic [31:0]   base_reg;
    logic [CNT-1:0] col_reg;
    logic          rd_valid_reg;
    logic [CW-1:0] rd_col_reg;
    logic [7:0]    rd_data_reg;
    logic          hold_valid_reg;
    logic [31:0]   hold_addr_reg;
    logic [7:0]    hold_pix_reg;
    logic          out_valid_reg;
    logic [31:0]   out_addr_reg;
    logic [7:0]    out_pix_reg;
    logic          out_last_reg;
    logic [7:0]    tile_mem [NPX];

    logic          mem_we;
    logic          issuing;
    logic          out_free;
    logic          px_nz;
    logic          stage_adv;
    logic          rd_en;
    logic          hold_to_out;
    logic          flush;
    logic          row_done;
    logic [CW-1:0] rd_pcol;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rx;

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_pixel = out_pix_reg;
    assign out_last  = out_last_reg;

    assign rd_pcol = cmd_reg.hflip ? CW'(TILE_SIZE - 1) - col_reg[CW-1:0] : col_reg[CW-1:0];
    assign rd_addr = cmd_reg.addr[AW-1:0] + AW'(rd_pcol);
    assign rx      = cmd_reg.dx + 16'(rd_col_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid && q_data.is_render) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = B_ROW;
            end
            B_ROW: begin
                if (row_done) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // a nonzero pixel waits in the hold stage until the next one turns up or
    // the row ends, which is when its last flag is known
    always_comb begin
        q_pop       = (state_reg == B_IDLE) && q_valid;
        mem_we      = q_pop && !q_data.is_render;
        issuing     = (state_reg == B_ROW) && (col_reg < CNT'(TILE_SIZE));
        out_free    = !out_valid_reg || out_ready;
        px_nz       = (rd_data_reg != 8'd0);
        stage_adv   = !rd_valid_reg || !px_nz || !hold_valid_reg || out_free;
        rd_en       = issuing && stage_adv;
        hold_to_out = rd_valid_reg && px_nz && hold_valid_reg && out_free;
        row_done    = (state_reg == B_ROW) && !issuing && !rd_valid_reg
                      && (!hold_valid_reg || out_free);
        flush       = row_done && hold_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= B_IDLE;
            frame_width_reg <= FRAME_WIDTH_RST;
            rd_valid_reg    <= 1'b0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                frame_width_reg <= cfg_wdata;
            end
            if (stage_adv) begin
                rd_valid_reg <= rd_en;
            end
            if (rd_valid_reg && px_nz && stage_adv) begin
                hold_valid_reg <= 1'b1;
            end else if (flush) begin
                hold_valid_reg <= 1'b0;
            end
            if (hold_to_out || flush) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_data.is_render) begin
            cmd_reg <= q_data;
        end
        if (state_reg == B_MUL) begin
            base_reg <= 32'(cmd_reg.ry) * 32'(frame_width_reg);
            col_reg  <= '0;
        end else if (rd_en) begin
            col_reg <= col_reg + 1'b1;
        end
        if (rd_en) begin
            rd_col_reg <= col_reg[CW-1:0];
        end
        if (rd_valid_reg && px_nz && stage_adv) begin
            hold_addr_reg <= base_reg + 32'(rx);
            hold_pix_reg  <= rd_data_reg;
        end
        if (hold_to_out || flush) begin
            out_addr_reg <= hold_addr_reg;
            out_pix_reg  <= hold_pix_reg;
            out_last_reg <= flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tile_mem[q_data.addr[AW-1:0]] <= q_data.value;
        end
        if (rd_en) begin
            rd_data_reg <= tile_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tile_flip_color_key_blit.sv @@
// tile blitter: one TILE_SIZE x TILE_SIZE tile of 8-bit palette pixels,
// rendered a row at a time into frame buffer writes with a color key of zero.
// input channel s_*: kind in tuser (0 load pixel, 1 render row, 2 flip tile).
// a load stores one pixel, a flip mirrors the logical tile, a render emits one
// item on m_* per nonzero pixel of the row, left to right, tlast on the final
// one; a row of only zero pixels gives nothing.
// cfg_we/cfg_wdata write the frame width (row stride); change it only while
// the block is idle.
// accepted items pass through a two-entry command queue. flips and dropped
// items finish at the input; loads are written to the tile store by the back
// end. a render occupies the back end for the queue pop, the row base
// multiply, one tile store read per column and the drain of the read and
// hold stages, plus any output stall. the first write leaves once the next
// nonzero pixel or the row end is seen.
// if m_tready is low the back end stops reading the tile store and the queue
// fills, after which s_tready drops.
// reset clears control state and sets the frame width to 320; tile contents
// are undefined until loaded and no reset sweep is run.
`timescale 1ns / 1ps
`default_nettype none

module tile_flip_color_key_blit #(
    parameter int TILE_SIZE = tfck_pkg::TILE_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pixel_index, pixel_value, tile_row, dest_x, dest_y, flip_mode, zero pad
    input  wire logic [55:0] s_tdata,
    // kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // write_address, write_pixel
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    import tfck_pkg::*;

    logic        q_push, q_push_ready, q_pop, q_valid;
    cmd_t        q_push_data, q_pop_data;
    logic [31:0] out_addr;
    logic [7:0]  out_pixel;

    tfck_front #(
        .TILE_SIZE (TILE_SIZE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (s_tuser),
        .pixel_index (s_tdata[7:0]),
        .pixel_value (s_tdata[15:8]),
        .tile_row    (s_tdata[19:16]),
        .dest_x      (s_tdata[35:20]),
        .dest_y      (s_tdata[51:36]),
        .flip_mode   (s_tdata[53:52]),
        .push        (q_push),
        .push_data   (q_push_data),
        .push_ready  (q_push_ready)
    );

    tfck_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_pop_data)
    );

    tfck_back #(
        .TILE_SIZE (TILE_SIZE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_addr  (out_addr),
        .out_pixel (out_pixel),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_pixel, out_addr};

endmodule

`default_nettype wire

@@ tb/tile_flip_color_key_blit_tb.sv @@
`timescale 1ns / 1ps

module tile_flip_color_key_blit_tb;
    import tfck_pkg::*;

    localparam int          TILE          = 16;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          STALL_LIMIT   = 4000;
    localparam logic [1:0]  KIND_NONE     = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  pixel_index;
        logic [7:0]  pixel_value;
        logic [3:0]  tile_row;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [1:0]  flip_mode;
    } blit_cmd_t;

    typedef struct {
        logic [31:0] address;
        logic [7:0]  pixel;
        logic        last;
    } fb_write_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;  // pixel_index, pixel_value, tile_row, dest_x, dest_y, flip_mode
    logic [1:0]  s_tuser   = '0;  // kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;         // write_address, write_pixel
    logic        m_tlast;

    tile_flip_color_key_blit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state
    logic [7:0]  tile_img [TILE*TILE];
    logic [15:0] stride = FRAME_WIDTH_RST;
    fb_write_t   expected_writes [$];

    int mismatches    = 0;
    int writes_seen   = 0;
    int n_loads       = 0;
    int n_renders     = 0;
    int n_flips       = 0;
    int n_noops       = 0;
    int n_widths      = 0;
    int quiet_cycles  = 0;
    bit src_idle_on   = 1'b1;
    bit sink_stall_on = 1'b1;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic mirror_tile(input logic [1:0] mode);
        logic [7:0] t;
        if (mode[0]) begin
            for (int r = 0; r < TILE; r++)
                for (int c = 0; c < TILE / 2; c++) begin
                    t = tile_img[r*TILE + c];
                    tile_img[r*TILE + c] = tile_img[r*TILE + TILE - 1 - c];
                    tile_img[r*TILE + TILE - 1 - c] = t;
                end
        end
        if (mode[1]) begin
            for (int r = 0; r < TILE / 2; r++)
                for (int c = 0; c < TILE; c++) begin
                    t = tile_img[r*TILE + c];
                    tile_img[r*TILE + c] = tile_img[(TILE - 1 - r)*TILE + c];
                    tile_img[(TILE - 1 - r)*TILE + c] = t;
                end
        end
    endtask

    task automatic predict_blit(input blit_cmd_t cmd);
        int          src_row;
        int          src_col;
        int          first_new;
        logic [15:0] row_y;
        logic [15:0] col_x;
        logic [7:0]  px;
        fb_write_t   w;
        case (cmd.kind)
            KIND_LOAD: begin
                tile_img[cmd.pixel_index] = cmd.pixel_value;
                n_loads++;
            end
            KIND_FLIP: begin
                mirror_tile(cmd.flip_mode);
                n_flips++;
            end
            KIND_RENDER: begin
                n_renders++;
                first_new = expected_writes.size();
                src_row = cmd.flip_mode[1] ? TILE - 1 - cmd.tile_row : cmd.tile_row;
                row_y = cmd.dest_y + 16'(cmd.tile_row);
                for (int c = 0; c < TILE; c++) begin
                    src_col = cmd.flip_mode[0] ? TILE - 1 - c : c;
                    px = tile_img[src_row*TILE + src_col];
                    if (px != 8'd0) begin
                        col_x = cmd.dest_x + 16'(c);
                        w.address = 32'(row_y) * 32'(stride) + 32'(col_x);
                        w.pixel = px;
                        w.last = 1'b0;
                        expected_writes.push_back(w);
                    end
                end
                if (expected_writes.size() > first_new)
                    expected_writes[expected_writes.size() - 1].last = 1'b1;
            end
            default: n_noops++;
        endcase
    endtask

    // enters after a rising edge, returns just after the edge that took the item
    task automatic send_cmd(input blit_cmd_t cmd);
        @(negedge aclk);
        while (src_idle_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.kind;
        s_tdata  <= {2'b00, cmd.flip_mode, cmd.dest_y, cmd.dest_x, cmd.tile_row,
                     cmd.pixel_value, cmd.pixel_index};
        do @(posedge aclk); while (!s_tready);
        predict_blit(cmd);
    endtask

    task automatic wait_for_writes();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge aclk);
    endtask

    // transparent renders may still be running after the last write
    task automatic settle_idle();
        wait_for_writes();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_width(input logic [15:0] w);
        settle_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        stride = w;
        n_widths++;
    endtask

    function automatic blit_cmd_t make_cmd(input logic [1:0] kind, input logic [3:0] row,
                                           input logic [15:0] dx, input logic [15:0] dy,
                                           input logic [1:0] mode);
        blit_cmd_t cmd;
        cmd.kind        = kind;
        cmd.pixel_index = 8'($urandom);
        cmd.pixel_value = 8'($urandom);
        cmd.tile_row    = row;
        cmd.dest_x      = dx;
        cmd.dest_y      = dy;
        cmd.flip_mode   = mode;
        return cmd;
    endfunction

    function automatic blit_cmd_t make_load(input logic [7:0] idx, input logic [7:0] val);
        blit_cmd_t cmd;
        cmd = make_cmd(KIND_LOAD, 4'($urandom), 16'($urandom), 16'($urandom), 2'($urandom));
        cmd.pixel_index = idx;
        cmd.pixel_value = val;
        return cmd;
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(3))
            0:       return 16'hFFFF - 16'($urandom_range(20));
            1:       return 16'($urandom_range(20));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic blit_cmd_t random_cmd();
        int          pick;
        logic [7:0]  val;
        pick = $urandom_range(99);
        if (pick < 45) begin
            val = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
            return make_load(8'($urandom), val);
        end
        if (pick < 87)
            return make_cmd(KIND_RENDER, 4'($urandom), pick_coord(), pick_coord(),
                            2'($urandom));
        if (pick < 95)
            return make_cmd(KIND_FLIP, 4'($urandom), 16'($urandom), 16'($urandom),
                            2'($urandom));
        return make_cmd(KIND_NONE, 4'($urandom), 16'($urandom), 16'($urandom),
                        2'($urandom));
    endfunction

    // every entry is written here before any render or flip reads the tile
    task automatic test_fill_tile();
        logic [7:0] val;
        for (int i = 0; i < TILE*TILE; i++) begin
            if (i / TILE == 5)
                val = 8'd0;
            else if (i / TILE == 2)
                val = (i % 2) ? 8'd255 : 8'($urandom_range(1, 254));
            else
                val = ($urandom_range(9) < 3) ? 8'd0 : 8'($urandom);
            send_cmd(make_load(8'(i), val));
        end
        send_cmd(make_load(8'd32, 8'd1));
    endtask

    task automatic test_directed();
        // reset stride, no flip, full row, then both flips with coordinate wrap
        send_cmd(make_cmd(KIND_RENDER, 4'd2, 16'd0, 16'd0, 2'd0));
        send_cmd(make_cmd(KIND_RENDER, 4'd13, 16'hFFFF, 16'hFFFF, 2'd3));
        send_cmd(make_cmd(KIND_RENDER, 4'd15, 16'hFFF8, 16'hFFF0, 2'd1));
        send_cmd(make_cmd(KIND_RENDER, 4'd0, 16'd7, 16'd3, 2'd2));
        // all-transparent row, direct and through a vertical mirror
        send_cmd(make_cmd(KIND_RENDER, 4'd5, 16'd100, 16'd100, 2'd0));
        send_cmd(make_cmd(KIND_RENDER, 4'd10, 16'd100, 16'd100, 2'd2));
        // unused kind with every field set
        send_cmd(make_cmd(KIND_NONE, 4'd15, 16'hFFFF, 16'hFFFF, 2'd3));
        send_cmd(make_cmd(KIND_FLIP, 4'd0, 16'd0, 16'd0, 2'd0));
        send_cmd(make_cmd(KIND_RENDER, 4'd2, 16'd1, 16'd1, 2'd0));
        send_cmd(make_cmd(KIND_FLIP, 4'd0, 16'd0, 16'd0, 2'd1));
        send_cmd(make_cmd(KIND_RENDER, 4'd2, 16'd1, 16'd1, 2'd0));
        send_cmd(make_cmd(KIND_FLIP, 4'd0, 16'd0, 16'd0, 2'd2));
        send_cmd(make_cmd(KIND_RENDER, 4'd13, 16'd0, 16'd0, 2'd0));
        send_cmd(make_cmd(KIND_FLIP, 4'd0, 16'd0, 16'd0, 2'd3));
        send_cmd(make_cmd(KIND_RENDER, 4'd2, 16'd0, 16'd0, 2'd0));
        // load extremes then render across them
        send_cmd(make_load(8'd0, 8'd0));
        send_cmd(make_load(8'd255, 8'd255));
        send_cmd(make_load(8'd15, 8'd1));
        send_cmd(make_cmd(KIND_RENDER, 4'd0, 16'd0, 16'd0, 2'd0));
        send_cmd(make_cmd(KIND_RENDER, 4'd15, 16'd0, 16'd0, 2'd3));
        send_cmd(make_cmd(KIND_RENDER, 4'd0, 16'd0, 16'd0, 2'd1));
    endtask

    task automatic test_width_extremes();
        logic [15:0] widths [4];
        widths = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom)};
        foreach (widths[i]) begin
            set_frame_width(widths[i]);
            send_cmd(make_cmd(KIND_RENDER, 4'd2, 16'hFFFF, 16'hFFFF, 2'd0));
            send_cmd(make_cmd(KIND_RENDER, 4'd13, 16'd0, 16'd0, 2'd2));
            send_cmd(make_cmd(KIND_RENDER, 4'($urandom), pick_coord(), pick_coord(),
                              2'($urandom)));
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        blit_cmd_t cmd;
        int        done;
        done = 0;
        while (done < n_items) begin
            src_idle_on   = !(done >= n_items / 3 && done < 2 * n_items / 3);
            sink_stall_on = src_idle_on;
            cmd = random_cmd();
            send_cmd(cmd);
            if (cmd.kind != KIND_NONE)
                done++;
            if (done == n_items / 4 && cmd.kind != KIND_NONE)
                wait_for_writes();
            if (done == n_items / 2 && cmd.kind != KIND_NONE)
                set_frame_width(16'($urandom_range(1, 4000)));
        end
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            m_tready <= sink_stall_on ? ($urandom_range(99) >= 13) : 1'b1;
        end
    end

    fb_write_t got_w;
    fb_write_t want_w;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            writes_seen++;
            got_w.address = m_tdata[31:0];
            got_w.pixel   = m_tdata[39:32];
            got_w.last    = m_tlast;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected write addr=%h pixel=%h last=%b",
                             $realtime, got_w.address, got_w.pixel, got_w.last);
            end else begin
                want_w = expected_writes.pop_front();
                if (got_w.address !== want_w.address || got_w.pixel !== want_w.pixel ||
                    got_w.last !== want_w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: write mismatch exp addr=%h pixel=%h last=%b,",
                                  " got addr=%h pixel=%h last=%b"},
                                 $realtime, want_w.address, want_w.pixel, want_w.last,
                                 got_w.address, got_w.pixel, got_w.last);
                end
            end
        end
    end

    // nothing moving on either side for too long means the block hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("timeout with %0d writes outstanding", expected_writes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TILE*TILE; i++)
            tile_img[i] = 8'd0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_tile();
        test_directed();
        test_width_extremes();
        test_random_traffic(150);

        settle_idle();
        if (expected_writes.size() != 0) begin
            mismatches += expected_writes.size();
            $display("%0d expected writes never arrived", expected_writes.size());
        end
        $display("covered %0d loads, %0d renders, %0d flips, %0d unused-kind items",
                 n_loads, n_renders, n_flips, n_noops);
        $display("checked %0d frame writes over %0d frame width settings, %0d mismatches",
                 writes_seen, n_widths + 1, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
